// ----- rtl/tlpte_pkg.sv -----
// tlpte_pkg: shared types and fixed constants for the two-level page table engine
// depends on nothing; used by every module of the engine
`default_nettype none

package tlpte_pkg;

  // fixed field widths of the request and result
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int VPN_W    = 20;
  localparam int FRAME_W  = 20;
  localparam int IDX_W    = 10;
  // entry word: present bit above the frame
  localparam int ENTRY_W  = FRAME_W + 1;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_TABLE   = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR,
    S_ENT_RD,
    S_ENT,
    S_HOLD
  } state_t;

  // memory port command
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/two_level_page_table_engine_unit.sv -----
// two_level_page_table_engine_unit: top level of the two-level page table engine
// depends on tlpte_pkg, tlpte_ctrl, tlpte_dir_mem, tlpte_entry_mem
//
//  channel  | ports                  | contents
//  ---------+------------------------+----------------------------------------------
//  request  | in_tvalid/tready/tdata | tuser: opcode; tdata: virt_page, phys_frame
//  result   | out_tvalid/tready/tdata| tuser: status; tdata: found_frame
//
//  a request first reads the directory and is finished there when rejected; map then
//  writes the entry, while unmap or lookup read the entry store before finishing
//  one request in flight; the result register lets the next request enter while
//  the previous result waits on out_tready
//  after reset a sweep clears both memories while in_tready stays low
`default_nettype none

module two_level_page_table_engine_unit #(
  parameter int DIR_ENTRIES       = 1024,
  parameter int ENTRIES_PER_TABLE = 1024,
  parameter int TABLE_SLOTS       = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [39:0]                      in_tdata,  // virt_page[19:0], phys_frame[39:20]
  input  wire [tlpte_pkg::OP_W-1:0]       in_tuser,  // opcode[1:0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [23:0]                     out_tdata, // found_frame[19:0], zero fill
  output logic [tlpte_pkg::STATUS_W-1:0]  out_tuser  // status[1:0]
);

  localparam int DIR_AW   = $clog2(DIR_ENTRIES);
  localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ST_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  tlpte_pkg::mem_cmd_t           dir_cmd, st_cmd;
  logic [DIR_AW-1:0]             dir_addr;
  logic [SLOT_W:0]               dir_wdata, dir_rdata;
  logic [ST_AW-1:0]              st_addr;
  logic [tlpte_pkg::ENTRY_W-1:0] st_wdata, st_rdata;

  // sequencer
  tlpte_ctrl #(
    .DIR_ENTRIES       (DIR_ENTRIES),
    .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
    .TABLE_SLOTS       (TABLE_SLOTS),
    .DIR_AW            (DIR_AW),
    .SLOT_W            (SLOT_W),
    .ST_DEPTH          (ST_DEPTH),
    .ST_AW             (ST_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .dir_cmd    (dir_cmd),
    .dir_addr   (dir_addr),
    .dir_wdata  (dir_wdata),
    .dir_rdata  (dir_rdata),
    .st_cmd     (st_cmd),
    .st_addr    (st_addr),
    .st_wdata   (st_wdata),
    .st_rdata   (st_rdata)
  );

  // directory: present bit over slot index
  tlpte_dir_mem #(
    .DEPTH (DIR_ENTRIES),
    .AW    (DIR_AW),
    .DW    (SLOT_W + 1)
  ) u_dir (
    .clk   (clk),
    .cmd   (dir_cmd),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  // second-level tables, one block of ENTRIES_PER_TABLE per slot
  tlpte_entry_mem #(
    .DEPTH (ST_DEPTH),
    .AW    (ST_AW)
  ) u_store (
    .clk   (clk),
    .cmd   (st_cmd),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/tlpte_dir_mem.sv -----
// tlpte_dir_mem: directory memory, one port, registered read data
// depends on tlpte_pkg (mem_cmd_t)
`default_nettype none

module tlpte_dir_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 5
) (
  input  wire                      clk,
  input  wire tlpte_pkg::mem_cmd_t cmd,
  input  wire [AW-1:0]             addr,
  input  wire [DW-1:0]             wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write has priority; read data registered
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end else if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tlpte_entry_mem.sv -----
// tlpte_entry_mem: second-level entry store, one port, registered read data
// depends on tlpte_pkg (mem_cmd_t, ENTRY_W)
`default_nettype none

module tlpte_entry_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire                            clk,
  input  wire tlpte_pkg::mem_cmd_t       cmd,
  input  wire [AW-1:0]                   addr,
  input  wire [tlpte_pkg::ENTRY_W-1:0]   wdata,
  output logic [tlpte_pkg::ENTRY_W-1:0]  rdata
);

  logic [tlpte_pkg::ENTRY_W-1:0] mem [DEPTH];

  // write has priority; read data registered
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end else if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tlpte_ctrl.sv -----
// tlpte_ctrl: request sequencer, slot allocator, clearing sweep and result register
// depends on tlpte_pkg; drives tlpte_dir_mem and tlpte_entry_mem
`default_nettype none

module tlpte_ctrl #(
  parameter int DIR_ENTRIES       = 1024,
  parameter int ENTRIES_PER_TABLE = 1024,
  parameter int TABLE_SLOTS       = 16,
  parameter int DIR_AW            = 10,
  parameter int SLOT_W            = 4,
  parameter int ST_DEPTH          = 16384,
  parameter int ST_AW             = 14
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [39:0]                       in_tdata,
  input  wire [tlpte_pkg::OP_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [23:0]                      out_tdata,
  output logic [tlpte_pkg::STATUS_W-1:0]   out_tuser,
  output tlpte_pkg::mem_cmd_t              dir_cmd,
  output logic [DIR_AW-1:0]                dir_addr,
  output logic [SLOT_W:0]                  dir_wdata,
  input  wire [SLOT_W:0]                   dir_rdata,
  output tlpte_pkg::mem_cmd_t              st_cmd,
  output logic [ST_AW-1:0]                 st_addr,
  output logic [tlpte_pkg::ENTRY_W-1:0]    st_wdata,
  input  wire [tlpte_pkg::ENTRY_W-1:0]     st_rdata
);

  localparam int IXW       = tlpte_pkg::IDX_W + 1;
  localparam int NS_W      = $clog2(TABLE_SLOTS + 1);
  localparam int CLR_DEPTH = (ST_DEPTH > DIR_ENTRIES) ? ST_DEPTH : DIR_ENTRIES;
  localparam int CNT_W     = $clog2(CLR_DEPTH + 1);
  localparam int FW        = tlpte_pkg::FRAME_W;

  tlpte_pkg::state_t state_r, state_nxt;
  tlpte_pkg::op_t    op_r;
  logic [tlpte_pkg::VPN_W-1:0] vp_r;
  logic [FW-1:0]               frame_r;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic [ST_AW-1:0]            pos_r;
  logic [NS_W-1:0]             next_slot_r;
  logic [CNT_W-1:0]            clr_cnt_r;
  logic                        out_valid_r;
  tlpte_pkg::status_t          out_status_r, res_status_r;
  logic [FW-1:0]               out_frame_r, res_frame_r;

  logic                        accept, clr_active, out_free;
  logic                        fin;
  tlpte_pkg::status_t          fin_status;
  logic [FW-1:0]               fin_frame;
  logic                        alloc;
  logic [tlpte_pkg::IDX_W-1:0] di, ei, in_di;
  logic                        in_range, dir_present, exhausted;
  logic [ST_AW-1:0]            pos;
  logic                        dir_seq_wr, st_seq_wr, st_seq_rd;
  logic [tlpte_pkg::ENTRY_W-1:0] st_seq_wdata;

  // request fields and index decode
  assign di          = vp_r[tlpte_pkg::VPN_W-1:tlpte_pkg::IDX_W];
  assign ei          = vp_r[tlpte_pkg::IDX_W-1:0];
  assign in_di       = in_tdata[tlpte_pkg::VPN_W-1:tlpte_pkg::IDX_W];
  assign in_range    = ({1'b0, di} < IXW'(DIR_ENTRIES)) &&
                       ({1'b0, ei} < IXW'(ENTRIES_PER_TABLE));
  assign dir_present = dir_rdata[SLOT_W];
  assign exhausted   = (next_slot_r == NS_W'(TABLE_SLOTS));
  assign pos         = ST_AW'(slot_r) * ST_AW'(ENTRIES_PER_TABLE) + ST_AW'(ei);

  // handshake
  assign clr_active  = (clr_cnt_r != CNT_W'(CLR_DEPTH));
  assign in_tready   = (state_r == tlpte_pkg::S_IDLE) && !clr_active;
  assign accept      = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = {4'b0, out_frame_r};
  assign out_tuser   = out_status_r;

  // next state and sequencer outputs
  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    fin          = 1'b0;
    fin_status   = tlpte_pkg::ST_OK;
    fin_frame    = '0;
    alloc        = 1'b0;
    dir_seq_wr   = 1'b0;
    st_seq_wr    = 1'b0;
    st_seq_rd    = 1'b0;
    st_seq_wdata = '0;
    unique case (state_r)
      tlpte_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = tlpte_pkg::S_DIR;
        end
      end
      tlpte_pkg::S_DIR: begin
        unique case (op_r) inside
          tlpte_pkg::OP_MAP: begin
            if (!in_range) begin
              fin        = 1'b1;
              fin_status = tlpte_pkg::ST_NOT_MAPPED;
            end else if (dir_present) begin
              slot_nxt  = dir_rdata[SLOT_W-1:0];
              state_nxt = tlpte_pkg::S_ENT_RD;
            end else if (exhausted) begin
              fin        = 1'b1;
              fin_status = tlpte_pkg::ST_NO_TABLE;
            end else begin
              alloc      = 1'b1;
              dir_seq_wr = 1'b1;
              slot_nxt   = next_slot_r[SLOT_W-1:0];
              state_nxt  = tlpte_pkg::S_ENT_RD;
            end
          end
          tlpte_pkg::OP_UNMAP, tlpte_pkg::OP_LOOKUP: begin
            if (!in_range || !dir_present) begin
              fin        = 1'b1;
              fin_status = tlpte_pkg::ST_NOT_MAPPED;
            end else begin
              slot_nxt  = dir_rdata[SLOT_W-1:0];
              state_nxt = tlpte_pkg::S_ENT_RD;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = tlpte_pkg::ST_NOT_MAPPED;
          end
        endcase
      end
      tlpte_pkg::S_ENT_RD: begin
        if (op_r == tlpte_pkg::OP_MAP) begin
          st_seq_wr    = 1'b1;
          st_seq_wdata = {1'b1, frame_r};
          fin          = 1'b1;
        end else begin
          st_seq_rd = 1'b1;
          state_nxt = tlpte_pkg::S_ENT;
        end
      end
      tlpte_pkg::S_ENT: begin
        fin = 1'b1;
        if (!st_rdata[FW]) begin
          fin_status = tlpte_pkg::ST_NOT_MAPPED;
        end else if (op_r == tlpte_pkg::OP_UNMAP) begin
          st_seq_wr = 1'b1;
        end else begin
          fin_frame = st_rdata[FW-1:0];
        end
      end
      tlpte_pkg::S_HOLD: begin
        if (out_free) begin
          state_nxt = tlpte_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlpte_pkg::S_IDLE;
      end
    endcase
    // a finished request goes straight out or parks in the hold registers
    if (fin) begin
      state_nxt = out_free ? tlpte_pkg::S_IDLE : tlpte_pkg::S_HOLD;
    end
  end

  // directory port: clearing sweep, lookup at accept, allocation write
  always_comb begin
    dir_cmd.rd = accept;
    dir_cmd.wr = dir_seq_wr;
    dir_addr   = accept ? in_di[DIR_AW-1:0] : di[DIR_AW-1:0];
    dir_wdata  = {1'b1, slot_nxt};
    if (clr_active) begin
      dir_cmd.rd = 1'b0;
      dir_cmd.wr = (clr_cnt_r < CNT_W'(DIR_ENTRIES));
      dir_addr   = clr_cnt_r[DIR_AW-1:0];
      dir_wdata  = '0;
    end
  end

  // entry store port: clearing sweep, entry read, map or unmap write
  always_comb begin
    st_cmd.rd = st_seq_rd;
    st_cmd.wr = st_seq_wr;
    st_addr   = (state_r == tlpte_pkg::S_ENT) ? pos_r : pos;
    st_wdata  = st_seq_wdata;
    if (clr_active) begin
      st_cmd.rd = 1'b0;
      st_cmd.wr = (clr_cnt_r < CNT_W'(ST_DEPTH));
      st_addr   = clr_cnt_r[ST_AW-1:0];
      st_wdata  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpte_pkg::S_IDLE;
      next_slot_r <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_active) begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      end
      if (alloc) begin
        next_slot_r <= next_slot_r + NS_W'(1);
      end
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == tlpte_pkg::S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= tlpte_pkg::op_t'(in_tuser);
      vp_r    <= in_tdata[tlpte_pkg::VPN_W-1:0];
      frame_r <= in_tdata[tlpte_pkg::VPN_W+FW-1:tlpte_pkg::VPN_W];
    end
    slot_r <= slot_nxt;
    if (state_r == tlpte_pkg::S_ENT_RD) begin
      pos_r <= pos;
    end
    if (fin) begin
      if (out_free) begin
        out_status_r <= fin_status;
        out_frame_r  <= fin_frame;
      end else begin
        res_status_r <= fin_status;
        res_frame_r  <= fin_frame;
      end
    end else if (state_r == tlpte_pkg::S_HOLD && out_free) begin
      out_status_r <= res_status_r;
      out_frame_r  <= res_frame_r;
    end
  end

  // checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active |-> !in_tready)
    else $error("request taken during clearing sweep");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= NS_W'(TABLE_SLOTS))
    else $error("slot pool overrun");

  a_dir_wr_place: assert property (@(posedge clk) disable iff (!rst_n)
    dir_cmd.wr |-> clr_active || (state_r == tlpte_pkg::S_DIR && op_r == tlpte_pkg::OP_MAP))
    else $error("directory written outside map allocation");

  a_alloc_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |-> !exhausted && !dir_present)
    else $error("allocation with present entry or empty pool");

  a_st_wr_place: assert property (@(posedge clk) disable iff (!rst_n)
    (st_cmd.wr && !clr_active) |->
      (state_r == tlpte_pkg::S_ENT_RD) || (state_r == tlpte_pkg::S_ENT))
    else $error("entry store written outside entry stage");

endmodule

`default_nettype wire
